@@ hw/rtl/sre_pkg.sv @@
package sre_pkg;

  localparam int NODES_DEF = 32;
  localparam int ADJ_ENTRIES_DEF = 128;
  localparam int PATH_HOPS = 32;

  localparam logic [31:0] DIST_INF = 32'hFFFF_FFFF;
  localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFE;

  localparam logic [1:0] KIND_ROOM = 2'd1;
  localparam logic [1:0] KIND_EXIT = 2'd2;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_NODE = 2'd1;
  localparam logic [1:0] REQ_ADJ = 2'd2;
  localparam logic [1:0] REQ_QUERY = 2'd3;

  typedef struct packed {
    logic [4:0] src;
    logic [4:0] dst;
    logic [7:0] edge_id;
    logic [23:0] cost;
    logic usable;
  } adj_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK_ROOM,
    S_CHK_EXIT,
    S_INIT,
    S_SCAN,
    S_SCAN_END,
    S_RA,
    S_RC,
    S_RD,
    S_PATH,
    S_COST,
    S_WI,
    S_WD,
    S_ERD,
    S_EOUT,
    S_FAIL
  } state_t;

endpackage

@@ hw/rtl/shortest_route_engine_top.sv @@
// Shortest route engine. Clear, node load and adjacency load transactions are
// taken in the idle state. A route query runs Dijkstra from the room: each round
// scans all NODES distances through one memory read port, then walks the
// adjacency list once, with an extra relax step for each usable entry leaving
// the settled node towards an active node, through one add-and-compare unit.
// After the last round it walks the predecessor path back from the exit, then
// emits one result per hop. The input is not ready while a query runs;
// results leave through an output register so the next transaction is taken
// while the last result waits. No clearing pass is needed after reset.
module shortest_route_engine_top #(
  parameter int NODES = sre_pkg::NODES_DEF,
  parameter int ADJ_ENTRIES = sre_pkg::ADJ_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] req_type,
  input  logic [4:0] node,
  input  logic node_active,
  input  logic [1:0] node_kind,
  input  logic [4:0] from_node,
  input  logic [4:0] to_node,
  input  logic [7:0] edge_ident,
  input  logic [23:0] weight,
  input  logic edge_active,
  input  logic [4:0] room,
  input  logic [4:0] exit_node,
  output logic out_valid,
  input  logic out_ready,
  output logic [4:0] route_room,
  output logic [4:0] route_exit,
  output logic reachable,
  output logic [31:0] cost,
  output logic [4:0] hop_node,
  output logic [7:0] hop_edge,
  output logic hop_edge_valid,
  output logic [4:0] hop_index,
  output logic last
);
  import sre_pkg::*;

  localparam int NW = $clog2(NODES);
  localparam int AW = (ADJ_ENTRIES > 1) ? $clog2(ADJ_ENTRIES) : 1;
  localparam int CW = $clog2(ADJ_ENTRIES + 1);

  state_t state, state_next;

  logic [NODES-1:0] node_on;
  logic [1:0] node_kd [NODES];
  logic [CW-1:0] adj_count;

  logic [4:0] room_r, exit_r;
  logic [NODES-1:0] reached, settled;
  logic [NW:0] sc;
  logic [NW-1:0] tag;
  logic tv;
  logic found;
  logic [NW-1:0] best;
  logic [31:0] bd;
  logic [CW-1:0] j;
  logic [NW-1:0] cur;
  logic [5:0] n;
  logic [4:0] k;
  logic [31:0] cost_r;

  adj_t adj_q, adj_w;
  logic adj_we;

  logic [31:0] dist_mem [NODES];
  logic [31:0] dist_q;
  logic [NW-1:0] dra, dwa;
  logic dwe;
  logic [31:0] dwd;

  logic [NW-1:0] pn_mem [NODES];
  logic [7:0] pe_mem [NODES];
  logic [NW-1:0] pn_q;
  logic [7:0] pe_q;

  logic [12:0] pb_mem [PATH_HOPS];
  logic [12:0] pb_q;
  logic [4:0] pb_ra;

  logic [4:0] nq;
  logic nq_in;
  logic [NW-1:0] nq_i;
  logic nq_on;
  logic [1:0] nq_kind;
  logic adj_match;
  logic [32:0] cand_w;
  logic [31:0] cand;
  logic relax_wr;
  logic out_free;
  logic out_load;
  logic acc;
  logic [NW-1:0] a_dst;

  assign acc = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign out_load = out_free && (state == S_EOUT || state == S_FAIL);
  assign in_ready = (state == S_IDLE);

  assign adj_w = '{src: from_node, dst: to_node, edge_id: edge_ident, cost: weight,
                   usable: edge_active};
  assign adj_we = acc && (req_type == REQ_ADJ) && (32'(adj_count) < ADJ_ENTRIES);

  sre_adj_mem #(.DEPTH(ADJ_ENTRIES), .AW(AW)) u_adj (
    .clk(clk),
    .we(adj_we),
    .waddr(adj_count[AW-1:0]),
    .wdata(adj_w),
    .raddr(j[AW-1:0]),
    .rdata(adj_q)
  );

  always_comb begin
    case (state)
      S_CHK_EXIT: nq = exit_r;
      S_RC: nq = adj_q.dst;
      default: nq = room_r;
    endcase
  end
  assign nq_in = 32'(nq) < NODES;
  assign nq_i = NW'(nq);
  assign nq_on = nq_in && node_on[nq_i];
  assign nq_kind = node_kd[nq_i];
  assign a_dst = NW'(adj_q.dst);

  assign adj_match = (32'(adj_q.src) == 32'(best)) && nq_on && adj_q.usable;
  assign cand_w = {1'b0, bd} + 33'(adj_q.cost);
  assign cand = (cand_w > {1'b0, DIST_MAX}) ? DIST_MAX : cand_w[31:0];
  assign relax_wr = (state == S_RD) && (!reached[a_dst] || cand < dist_q);

  always_comb begin
    case (state)
      S_SCAN: dra = sc[NW-1:0];
      S_RC, S_RD: dra = a_dst;
      default: dra = NW'(exit_r);
    endcase
    dwe = 1'b0;
    dwa = a_dst;
    dwd = cand;
    if (state == S_INIT) begin
      dwe = 1'b1;
      dwa = NW'(room_r);
      dwd = '0;
    end else if (relax_wr) begin
      dwe = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dwe) begin
      dist_mem[dwa] <= dwd;
    end
    dist_q <= dist_mem[dra];
  end

  always_ff @(posedge clk) begin
    if (relax_wr) begin
      pn_mem[a_dst] <= best;
      pe_mem[a_dst] <= adj_q.edge_id;
    end
    pn_q <= pn_mem[cur];
    pe_q <= pe_mem[cur];
  end

  assign pb_ra = 5'(n - 6'd1) - k;

  always_ff @(posedge clk) begin
    if (state == S_WI && cur == NW'(room_r)) begin
      pb_mem[5'(n - 6'd1)] <= {5'(cur), 8'd0};
    end else if (state == S_WD) begin
      pb_mem[5'(n - 6'd1)] <= {5'(cur), pe_q};
    end
    pb_q <= pb_mem[pb_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc && req_type == REQ_QUERY) state_next = S_CHK_ROOM;
      end
      S_CHK_ROOM: state_next = (nq_on && nq_kind == KIND_ROOM) ? S_CHK_EXIT : S_FAIL;
      S_CHK_EXIT: state_next = (nq_on && nq_kind == KIND_EXIT) ? S_INIT : S_FAIL;
      S_INIT: state_next = S_SCAN;
      S_SCAN: begin
        if (sc == (NW + 1)'(NODES) && !tv) state_next = S_SCAN_END;
      end
      S_SCAN_END: state_next = found ? S_RA : S_PATH;
      S_RA: state_next = (j == adj_count) ? S_SCAN : S_RC;
      S_RC: state_next = adj_match ? S_RD : S_RA;
      S_RD: state_next = S_RA;
      S_PATH: state_next = reached[NW'(exit_r)] ? S_COST : S_FAIL;
      S_COST: state_next = S_WI;
      S_WI: begin
        if (cur == NW'(room_r)) state_next = S_ERD;
        else if (n == 6'(PATH_HOPS)) state_next = S_FAIL;
        else state_next = S_WD;
      end
      S_WD: state_next = S_WI;
      S_ERD: state_next = S_EOUT;
      S_EOUT: begin
        if (out_free) state_next = (6'(k) == n - 6'd1) ? S_IDLE : S_ERD;
      end
      S_FAIL: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_on <= '0;
      adj_count <= '0;
      reached <= '0;
      settled <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc) begin
            case (req_type)
              REQ_CLEAR: begin
                node_on <= '0;
                for (int i = 0; i < NODES; i++) node_kd[i] <= '0;
                adj_count <= '0;
              end
              REQ_NODE: begin
                if (32'(node) < NODES) begin
                  node_on[NW'(node)] <= node_active;
                  node_kd[NW'(node)] <= node_kind;
                end
              end
              REQ_ADJ: begin
                if (adj_we) adj_count <= adj_count + CW'(1);
              end
              default: begin
                room_r <= room;
                exit_r <= exit_node;
              end
            endcase
          end
        end
        S_INIT: begin
          reached <= NODES'(1) << NW'(room_r);
          settled <= '0;
          sc <= '0;
          tv <= 1'b0;
          found <= 1'b0;
          bd <= DIST_INF;
        end
        S_SCAN: begin
          if (sc != (NW + 1)'(NODES)) begin
            tag <= sc[NW-1:0];
            tv <= 1'b1;
            sc <= sc + 1'b1;
          end else begin
            tv <= 1'b0;
          end
          if (tv && reached[tag] && !settled[tag] && dist_q < bd) begin
            bd <= dist_q;
            best <= tag;
            found <= 1'b1;
          end
        end
        S_SCAN_END: begin
          if (found) settled[best] <= 1'b1;
          j <= '0;
        end
        S_RA: begin
          if (j == adj_count) begin
            sc <= '0;
            tv <= 1'b0;
            found <= 1'b0;
            bd <= DIST_INF;
          end
        end
        S_RC: begin
          if (!adj_match) j <= j + CW'(1);
        end
        S_RD: begin
          if (relax_wr) reached[a_dst] <= 1'b1;
          j <= j + CW'(1);
        end
        S_COST: begin
          cost_r <= dist_q;
          cur <= NW'(exit_r);
          n <= 6'd1;
        end
        S_WD: begin
          cur <= pn_q;
          n <= n + 6'd1;
        end
        S_WI: begin
          k <= '0;
        end
        S_EOUT: begin
          if (out_free) begin
            route_room <= room_r;
            route_exit <= exit_r;
            reachable <= 1'b1;
            cost <= cost_r;
            hop_node <= pb_q[12:8];
            hop_edge <= (k == '0) ? 8'd0 : pb_q[7:0];
            hop_edge_valid <= (k != '0);
            hop_index <= k;
            last <= (6'(k) == n - 6'd1);
            k <= k + 5'd1;
          end
        end
        S_FAIL: begin
          if (out_free) begin
            route_room <= room_r;
            route_exit <= exit_r;
            reachable <= 1'b0;
            cost <= DIST_INF;
            hop_node <= '0;
            hop_edge <= '0;
            hop_edge_valid <= 1'b0;
            hop_index <= '0;
            last <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && req_type == REQ_QUERY) |=> !in_ready)
    else $error("input ready right after a query transaction");

  a_adj_cap: assert property (@(posedge clk) disable iff (rst)
    32'(adj_count) <= ADJ_ENTRIES)
    else $error("adjacency count beyond capacity");

  a_fail_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !reachable) |-> (last && hop_index == '0 && cost == DIST_INF))
    else $error("unreachable result malformed");

  a_relax_settled: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> settled[best])
    else $error("relaxing from a node that is not settled");

endmodule

@@ hw/rtl/sre_adj_mem.sv @@
module sre_adj_mem #(
  parameter int DEPTH = 128,
  parameter int AW = 7
) (
  input  logic clk,
  input  logic we,
  input  logic [AW-1:0] waddr,
  input  sre_pkg::adj_t wdata,
  input  logic [AW-1:0] raddr,
  output sre_pkg::adj_t rdata
);
  import sre_pkg::*;

  adj_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
